// ----- rtl/deq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Operation and status codes used by the double-ended queue top.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 5;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [WORD_W-1:0]   word_t;

  localparam op_t OP_PUSH_FRONT = 3'd0;
  localparam op_t OP_PUSH_BACK  = 3'd1;
  localparam op_t OP_POP_FRONT  = 3'd2;
  localparam op_t OP_POP_BACK   = 3'd3;
  localparam op_t OP_STATUS     = 3'd4;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_UNDERFLOW = 2'd1;
  localparam status_t ST_OVERFLOW  = 2'd2;

  localparam word_t EMPTY_WORD = 32'hFFFF_FFFF;

endpackage

// ----- rtl/deq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/double_ended_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of 32-bit words kept in a ring RAM.
// ----------------------------------------------------------------------------
// an accepted item steps through S_READ and S_DONE, and its result is registered
//   as S_DONE returns to S_IDLE; a new item is taken only back in S_IDLE, after
//   the registered ram read of the front and rear entries after the pointer update
// a finished result waits in the output register while the next item runs
// reset: synchronous active-low rst_n clears pointers, count and handshake
//   state; ram contents stay undefined and are never used before written
module double_ended_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_front_value,
  output logic [31:0] out_rear_value,
  output logic [4:0]  out_element_count,
  output logic        out_is_empty
);

  localparam int AW    = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DONE
  } state_t;

  state_t                 state_r;
  logic [AW-1:0]          head_r, head_nxt;
  logic [AW-1:0]          tail_r, tail_nxt;
  logic [OCC_W-1:0]       occ_r, occ_nxt;
  deq_pkg::status_t       status_r, status_nxt;
  logic                   out_valid_r;
  deq_pkg::status_t       out_status_r;
  deq_pkg::word_t         out_front_r, out_rear_r;
  logic [OCC_W-1:0]       out_occ_r;

  logic                   in_xfer;
  logic                   full, empty;
  logic [AW-1:0]          head_prev, head_next, tail_prev, tail_next;
  logic                   we;
  logic [AW-1:0]          waddr;
  deq_pkg::word_t         rdata_front, rdata_rear;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign full     = (occ_r == OCC_W'(DEPTH));
  assign empty    = (occ_r == '0);

  assign head_prev = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
  assign head_next = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_prev = (tail_r == '0) ? AW'(DEPTH - 1) : tail_r - 1'b1;
  assign tail_next = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    occ_nxt    = occ_r;
    status_nxt = deq_pkg::ST_OK;
    we         = 1'b0;
    waddr      = tail_r;
    if (in_xfer) begin
      unique case (in_operation)
        deq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status_nxt = deq_pkg::ST_OVERFLOW;
          end else begin
            head_nxt = head_prev;
            waddr    = head_prev;
            we       = 1'b1;
            occ_nxt  = occ_r + 1'b1;
          end
        end
        deq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status_nxt = deq_pkg::ST_OVERFLOW;
          end else begin
            tail_nxt = tail_next;
            waddr    = tail_r;
            we       = 1'b1;
            occ_nxt  = occ_r + 1'b1;
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            status_nxt = deq_pkg::ST_UNDERFLOW;
          end else begin
            head_nxt = head_next;
            occ_nxt  = occ_r - 1'b1;
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (empty) begin
            status_nxt = deq_pkg::ST_UNDERFLOW;
          end else begin
            tail_nxt = tail_prev;
            occ_nxt  = occ_r - 1'b1;
          end
        end
        default: begin
          status_nxt = deq_pkg::ST_OK;
        end
      endcase
    end
  end

  // reads follow the committed pointers, so no write overlaps a used read
  deq_ram #(
    .WIDTH (deq_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (in_value),
    .raddr_a (head_r),
    .raddr_b (tail_prev),
    .rdata_a (rdata_front),
    .rdata_b (rdata_rear)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      status_r    <= deq_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r  <= occ_nxt;
      if (in_xfer) begin
        status_r <= status_nxt;
      end
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_occ_r    <= occ_r;
            out_front_r  <= empty ? deq_pkg::EMPTY_WORD : rdata_front;
            out_rear_r   <= empty ? deq_pkg::EMPTY_WORD : rdata_rear;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_front_value   = out_front_r;
  assign out_rear_value    = out_rear_r;
  assign out_element_count = deq_pkg::COUNT_W'(out_occ_r);
  assign out_is_empty      = (out_occ_r == '0);

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !full && (in_operation == deq_pkg::OP_PUSH_FRONT ||
     in_operation == deq_pkg::OP_PUSH_BACK)) |=> occ_r == $past(occ_r) + 1'b1)
    else $error("accepted push did not grow the count");

  a_underflow_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && empty && (in_operation == deq_pkg::OP_POP_FRONT ||
     in_operation == deq_pkg::OP_POP_BACK))
    |=> $stable(occ_r) && $stable(head_r) && $stable(tail_r))
    else $error("pop of empty queue changed pointers");

  a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty)
    |-> (out_front_value == deq_pkg::EMPTY_WORD && out_rear_value == deq_pkg::EMPTY_WORD))
    else $error("empty result carries stored words");

endmodule
